FILE: src/szbes_pkg.sv
// Shared types and constants for the sparse zero-block extent splitter.
// Used by szbes_core, szbes_fifo and the top level; depends on nothing else.

package szbes_pkg;

   // Defaults for the top-level parameters. Block size must be a power of two.
   localparam int unsigned BLOCK_SIZE_DEFAULT  = 1024;
   localparam int unsigned LENGTH_BITS_DEFAULT = 32;

   localparam int unsigned POS_BITS       = 64;
   localparam int unsigned BYTE_BITS      = 8;
   // Reported extent lengths never carry more than this many low bits.
   localparam int unsigned OUT_LEN_LIMIT  = 32;

   // Result queue geometry.
   localparam int unsigned FIFO_DEPTH     = 4;
   localparam int unsigned FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   // Results pushed by the core in one cycle: slot1 is only used with slot0.
   typedef struct packed {
      logic slot0;
      logic slot1;
   } push_type;

   // Queue status seen by the core.
   typedef struct packed {
      logic room_for_two;
   } fifo_status_type;

endpackage

FILE: src/szbes_fifo.sv
// Small queue: takes up to two results per cycle, hands out one unless stalled.
// Depends on szbes_pkg for depth, pointer widths and the push/status structs.

module szbes_fifo #(
   parameter int unsigned ENTRY_BITS = 97
) (
   input  logic                            clock,
   input  logic                            reset,
   input  szbes_pkg::push_type             push,
   input  logic [ENTRY_BITS-1:0]           push_data0,
   input  logic [ENTRY_BITS-1:0]           push_data1,
   output szbes_pkg::fifo_status_type      status,
   output logic                            out_valid,
   input  logic                            out_stall,
   output logic [ENTRY_BITS-1:0]           out_data
);

   localparam int unsigned DEPTH    = szbes_pkg::FIFO_DEPTH;
   localparam int unsigned PTR_BITS = szbes_pkg::FIFO_PTR_BITS;
   localparam int unsigned CNT_BITS = szbes_pkg::FIFO_CNT_BITS;

   logic [ENTRY_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_ptr_next1;
   logic [CNT_BITS-1:0]   push_n;
   logic                  pop;

   assign out_valid    = (count_ff != '0);
   assign out_data     = mem_ff[rd_ptr_ff];
   assign pop          = out_valid && !out_stall;
   assign wr_ptr_next1 = wr_ptr_ff + PTR_BITS'(1);

   // Room is judged on the registered count only, so stall does not feed back.
   assign status.room_for_two = (count_ff <= CNT_BITS'(DEPTH - 2));

   always_comb begin
      push_n    = CNT_BITS'(push.slot0) + CNT_BITS'(push.slot1);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.slot0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.slot1) begin
         mem_ff[wr_ptr_next1] <= push_data1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("result queue count beyond depth");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      push.slot1 |-> push.slot0)
      else $error("second result pushed without first");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.slot0) |=> (count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("result queue count did not drop on pop");
`endif

endmodule

FILE: src/szbes_core.sv
// Request register plus one pass of chunk tracking and extent merging.
// Depends on szbes_pkg; feeds up to two results per request into szbes_fifo.

module szbes_core #(
   parameter int unsigned BLOCK_SIZE  = szbes_pkg::BLOCK_SIZE_DEFAULT,
   parameter int unsigned LENGTH_BITS = szbes_pkg::LENGTH_BITS_DEFAULT,
   parameter int unsigned ENTRY_BITS  = szbes_pkg::POS_BITS + LENGTH_BITS + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [szbes_pkg::BYTE_BITS-1:0]      req_byte_value,
   input  logic [szbes_pkg::POS_BITS-1:0]       req_start_position,
   input  logic                                 req_first_byte,
   input  logic                                 req_last_byte,
   input  szbes_pkg::fifo_status_type           status,
   output szbes_pkg::push_type                  push,
   output logic [ENTRY_BITS-1:0]                push_data0,
   output logic [ENTRY_BITS-1:0]                push_data1
);

   localparam int unsigned POS_BITS   = szbes_pkg::POS_BITS;
   localparam int unsigned BLOCK_BITS = $clog2(BLOCK_SIZE);
   localparam int unsigned CLEN_BITS  = BLOCK_BITS + 1;
   // Run length register: wide enough for a whole chunk, 64 bits if the
   // length field is too narrow for a full block.
   localparam int unsigned RUN_BITS   = (LENGTH_BITS > BLOCK_BITS) ? LENGTH_BITS : POS_BITS;
   localparam int unsigned SUM_BITS   = RUN_BITS + 1;
   localparam logic [64:0] LEN_MAX_W  = (65'd1 << LENGTH_BITS) - 65'd1;

   // Request register
   logic                        s1_valid_ff, s1_valid_in;
   logic [szbes_pkg::BYTE_BITS-1:0] s1_byte_ff;
   logic [POS_BITS-1:0]         s1_start_ff;
   logic                        s1_first_ff;
   logic                        s1_last_ff;
   logic                        accept;
   logic                        fire;

   // Stream state
   logic [POS_BITS-1:0]   cur_pos_ff,  cur_pos_in;
   logic [BLOCK_BITS-1:0] fill_ff,     fill_in;
   logic                  nonzero_ff,  nonzero_in;
   logic                  head_ff,     head_in;
   logic [POS_BITS-1:0]   run_start_ff, run_start_in;
   logic [RUN_BITS-1:0]   run_len_ff,  run_len_in;
   logic                  gap_ff,      gap_in;

   // Working values
   logic [POS_BITS-1:0]   e_pos, e_run_start, pos_next, c_start;
   logic [BLOCK_BITS-1:0] e_fill;
   logic                  e_nonzero, e_head, e_gap;
   logic [RUN_BITS-1:0]   e_run_len, c_run_len;
   logic [POS_BITS-1:0]   c_run_start;
   logic                  chunk_end, keep, emit_pend, c_gap;
   logic [CLEN_BITS-1:0]  clen;
   logic [SUM_BITS-1:0]   run_sum;
   logic                  clen_fits, saturate;
   logic [LENGTH_BITS-1:0] pend_len_out, done_len_out;
   logic [ENTRY_BITS-1:0] pend_entry, done_entry;

   assign fire        = s1_valid_ff && status.room_for_two;
   assign req_stall   = s1_valid_ff && !status.room_for_two;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff  <= req_byte_value;
         s1_start_ff <= req_start_position;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
      end
   end

   always_comb begin
      // A first byte reopens the buffer at its start offset.
      if (s1_first_ff) begin
         e_pos       = s1_start_ff;
         e_fill      = '0;
         e_nonzero   = 1'b0;
         e_head      = (s1_start_ff[BLOCK_BITS-1:0] != '0);
         e_run_start = s1_start_ff;
         e_run_len   = '0;
         e_gap       = 1'b0;
      end else begin
         e_pos       = cur_pos_ff;
         e_fill      = fill_ff;
         e_nonzero   = nonzero_ff;
         e_head      = head_ff;
         e_run_start = run_start_ff;
         e_run_len   = run_len_ff;
         e_gap       = gap_ff;
      end

      e_nonzero = e_nonzero || (s1_byte_ff != '0);
      pos_next  = e_pos + POS_BITS'(1);
      chunk_end = s1_last_ff || (&e_pos[BLOCK_BITS-1:0]);
      clen      = CLEN_BITS'(e_fill) + CLEN_BITS'(1);
      c_start   = e_pos - POS_BITS'(e_fill);
      keep      = e_head || e_nonzero;

      run_sum   = SUM_BITS'(e_run_len) + SUM_BITS'(clen);
      clen_fits = (65'(clen) <= LEN_MAX_W);
      saturate  = clen_fits && (65'(run_sum) > LEN_MAX_W);

      // Merge the closed chunk into the pending extent.
      emit_pend   = 1'b0;
      c_run_start = e_run_start;
      c_run_len   = e_run_len;
      c_gap       = e_gap;
      if (keep) begin
         if (e_gap || e_run_len == '0) begin
            emit_pend   = (e_run_len != '0);
            c_run_start = c_start;
            c_run_len   = RUN_BITS'(clen);
            c_gap       = 1'b0;
         end else begin
            c_run_len = saturate ? RUN_BITS'(LEN_MAX_W) : RUN_BITS'(run_sum);
         end
      end else begin
         c_gap = 1'b1;
      end

      // Reported lengths keep only the low bits of the field.
      for (int i = 0; i < LENGTH_BITS; i++) begin
         pend_len_out[i] = (i < szbes_pkg::OUT_LEN_LIMIT) ? e_run_len[i] : 1'b0;
         done_len_out[i] = (i < szbes_pkg::OUT_LEN_LIMIT) ? c_run_len[i] : 1'b0;
      end
      pend_entry = {e_run_start, pend_len_out, 1'b0};
      if (c_run_len != '0) begin
         done_entry = {c_run_start, done_len_out, 1'b1};
      end else begin
         done_entry = {POS_BITS'(0), LENGTH_BITS'(0), 1'b1};
      end

      // Next state
      cur_pos_in   = pos_next;
      fill_in      = e_fill;
      nonzero_in   = e_nonzero;
      head_in      = e_head;
      run_start_in = e_run_start;
      run_len_in   = e_run_len;
      gap_in       = e_gap;
      if (!chunk_end) begin
         fill_in = e_fill + BLOCK_BITS'(1);
      end else if (s1_last_ff) begin
         fill_in      = '0;
         nonzero_in   = 1'b0;
         head_in      = (pos_next[BLOCK_BITS-1:0] != '0);
         run_start_in = pos_next;
         run_len_in   = '0;
         gap_in       = 1'b0;
      end else begin
         fill_in      = '0;
         nonzero_in   = 1'b0;
         head_in      = 1'b0;
         run_start_in = c_run_start;
         run_len_in   = c_run_len;
         gap_in       = c_gap;
      end

      // Results: pending extent first, then the done mark.
      push.slot0 = fire && chunk_end && (emit_pend || s1_last_ff);
      push.slot1 = fire && chunk_end && emit_pend && s1_last_ff;
      push_data0 = emit_pend ? pend_entry : done_entry;
      push_data1 = done_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pos_ff   <= '0;
         fill_ff      <= '0;
         nonzero_ff   <= 1'b0;
         head_ff      <= 1'b0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         gap_ff       <= 1'b0;
      end else if (fire) begin
         cur_pos_ff   <= cur_pos_in;
         fill_ff      <= fill_in;
         nonzero_ff   <= nonzero_in;
         head_ff      <= head_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         gap_ff       <= gap_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty request register");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.slot0 |-> status.room_for_two)
      else $error("result pushed without queue room");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_last_ff) |=> (fill_ff == '0 && run_len_ff == '0 && !gap_ff))
      else $error("buffer state not reopened after last byte");
`endif

endmodule

FILE: src/sparse_zero_block_extent_splitter.sv
// Top level of the sparse zero-block extent splitter.
// Depends on szbes_pkg, szbes_core and szbes_fifo.
//
//   channel  prefix  direction  handshake       payload
//   request  req_    in         valid / stall   byte_value, start_position, first/last
//   result   rsp_    out        valid / stall   extent_position, extent_length, done
//
// One byte per cycle while not stalled; results go from the request register into a
// four-entry queue and leave it one per cycle while rsp_stall is low; every request
// needs two free entries in the queue to leave the request register.
// Reset is synchronous and clears the stream state to offset zero, no buffer open.
// Request stall rises only while the queue lacks room for two results.

module sparse_zero_block_extent_splitter #(
   parameter int unsigned BLOCK_SIZE  = szbes_pkg::BLOCK_SIZE_DEFAULT,
   parameter int unsigned LENGTH_BITS = szbes_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [szbes_pkg::BYTE_BITS-1:0]   req_byte_value,
   input  logic [szbes_pkg::POS_BITS-1:0]    req_start_position,
   input  logic                              req_first_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [szbes_pkg::POS_BITS-1:0]    rsp_extent_position,
   output logic [LENGTH_BITS-1:0]            rsp_extent_length,
   output logic                              rsp_buffer_done
);

   localparam int unsigned ENTRY_BITS = szbes_pkg::POS_BITS + LENGTH_BITS + 1;

   szbes_pkg::push_type         push;
   szbes_pkg::fifo_status_type  status;
   logic [ENTRY_BITS-1:0]       push_data0, push_data1, out_data;

   szbes_core #(
      .BLOCK_SIZE  (BLOCK_SIZE),
      .LENGTH_BITS (LENGTH_BITS),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_start_position (req_start_position),
      .req_first_byte     (req_first_byte),
      .req_last_byte      (req_last_byte),
      .status             (status),
      .push               (push),
      .push_data0         (push_data0),
      .push_data1         (push_data1)
   );

   szbes_fifo #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .status     (status),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (out_data)
   );

   assign rsp_extent_position = out_data[ENTRY_BITS-1 -: szbes_pkg::POS_BITS];
   assign rsp_extent_length   = out_data[LENGTH_BITS:1];
   assign rsp_buffer_done     = out_data[0];

endmodule
